// ----- design/fcd_pkg.sv -----
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types, constants and helper functions of the fault code display
// controller: fault levels, display characters, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fcd_pkg;

	// field widths
	localparam int FAULT_W         = 64;
	localparam int GENERAL_W       = 32;
	localparam int LEVEL_W         = 3;
	localparam int CHAR_W          = 8;
	localparam int IDX_W           = 6;
	localparam int HOLD_W          = 8;
	localparam int STEP_W          = 20;
	localparam int IDLE_COUNT_BITS = 20;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_STEP  = CFG_IDX_W'(1);

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(10);
	localparam logic [STEP_W-1:0] IDLE_STEP_RST  = STEP_W'(500);

	// fault levels
	localparam logic [LEVEL_W-1:0] LVL_NONE     = LEVEL_W'(0);
	localparam logic [LEVEL_W-1:0] LVL_CPU      = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] LVL_STATION  = LEVEL_W'(2);
	localparam logic [LEVEL_W-1:0] LVL_PLATFORM = LEVEL_W'(3);
	localparam logic [LEVEL_W-1:0] LVL_WARNING  = LEVEL_W'(4);
	localparam logic [LEVEL_W-1:0] LVL_GENERAL  = LEVEL_W'(5);

	// code offsets per fault source, all whole hundreds
	localparam int OFFSET_CPU      = 400;
	localparam int OFFSET_STATION  = 300;
	localparam int OFFSET_PLATFORM = 200;
	localparam int HUND_CPU        = OFFSET_CPU / 100;
	localparam int HUND_STATION    = OFFSET_STATION / 100;
	localparam int HUND_PLATFORM   = OFFSET_PLATFORM / 100;

	// characters
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
	localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
	localparam logic [CHAR_W-1:0] CH_W      = 8'h57;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;

	typedef logic [3:0][CHAR_W-1:0] code_t;

	localparam code_t CODE_IDLE = {CH_EQUAL, CH_EQUAL, CH_EQUAL, CH_DOLLAR};

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		code_t              code;
	} fcd_entry_t;

	// index of the lowest set bit; 63 when nothing is set
	function automatic logic [IDX_W-1:0] lowest_set_idx(input logic [FAULT_W-1:0] v);
		logic [FAULT_W-1:0] iso;
		logic [IDX_W-1:0]   idx;
		iso = v & (~v + FAULT_W'(1));
		for (int b = 0; b < IDX_W; b++) begin
			idx[b] = 1'b0;
			for (int i = 0; i < FAULT_W; i++) begin
				if (((i >> b) & 1) == 1) begin
					idx[b] = idx[b] | iso[i];
				end
			end
		end
		if (v == '0) begin
			idx = '1;
		end
		return idx;
	endfunction

	// three decimal characters for hundreds digit plus a 0..63 index
	function automatic logic [2:0][CHAR_W-1:0] dec_chars(input logic [3:0] hund,
			input logic [IDX_W-1:0] idx);
		logic [IDX_W+7:0] prod;
		logic [3:0]       tens;
		logic [3:0]       ones;
		// x * 205 >> 11 equals x / 10 for small x
		prod = (IDX_W + 8)'(idx) * (IDX_W + 8)'(205);
		tens = 4'(prod >> 11);
		ones = 4'(idx - IDX_W'(tens) * IDX_W'(10));
		return {CH_ZERO + 8'(ones), CH_ZERO + 8'(tens), CH_ZERO + 8'(hund)};
	endfunction

endpackage

`default_nettype wire

// ----- design/fcd_in_if.sv -----
// ----------------------------------------------------------------------------
// fcd_in_if
// Fault word channel: valid/ready handshake with the four fault words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcd_in_if
	import fcd_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [FAULT_W-1:0]   cpu_faults;
	logic [FAULT_W-1:0]   station_faults;
	logic [FAULT_W-1:0]   platform_faults;
	logic [GENERAL_W-1:0] general_error;

	modport source (
		output valid, cpu_faults, station_faults, platform_faults, general_error,
		input  ready
	);
	modport sink (
		input  valid, cpu_faults, station_faults, platform_faults, general_error,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/fcd_out_if.sv -----
// ----------------------------------------------------------------------------
// fcd_out_if
// Display channel: valid/ready handshake with level and four characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcd_out_if
	import fcd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] fault_level;
	logic [CHAR_W-1:0]  char0;
	logic [CHAR_W-1:0]  char1;
	logic [CHAR_W-1:0]  char2;
	logic [CHAR_W-1:0]  char3;
	logic               lcd_write;

	modport source (
		output valid, fault_level, char0, char1, char2, char3, lcd_write,
		input  ready
	);
	modport sink (
		input  valid, fault_level, char0, char1, char2, char3, lcd_write,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/fcd_front.sv -----
// ----------------------------------------------------------------------------
// fcd_front
// Accepts fault words, picks the most urgent fault by priority and builds
// its level and four-character code for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_front
	import fcd_pkg::*;
(
	fcd_in_if.sink     faults,
	input  wire logic  full,
	output logic       push,
	output fcd_entry_t entry
);

	logic [FAULT_W-1:0] sel_mask;
	logic [IDX_W-1:0]   idx;
	logic [CHAR_W-1:0]  lo_byte;
	logic [CHAR_W-1:0]  hex_char;

	assign faults.ready = !full;
	assign push         = faults.valid && !full;

	always_comb begin
		if (faults.cpu_faults != '0) begin
			sel_mask = faults.cpu_faults;
		end else if (faults.station_faults != '0) begin
			sel_mask = faults.station_faults;
		end else begin
			sel_mask = faults.platform_faults;
		end
		idx = lowest_set_idx(sel_mask);

		lo_byte  = faults.general_error[7:0];
		hex_char = (lo_byte < 8'd10) ? lo_byte + CH_ZERO : lo_byte - 8'd10 + CH_A;

		entry.level = LVL_NONE;
		entry.code  = '0;
		if (faults.cpu_faults != '0) begin
			entry.level      = LVL_CPU;
			entry.code[3:1]  = dec_chars(4'(HUND_CPU), idx);
			entry.code[0]    = CH_E;
		end else if (faults.station_faults != '0) begin
			entry.level      = LVL_STATION;
			entry.code[3:1]  = dec_chars(4'(HUND_STATION), idx);
			entry.code[0]    = CH_E;
		end else if (faults.platform_faults != '0) begin
			// upper half of the platform word holds warnings
			entry.level      = idx[IDX_W-1] ? LVL_WARNING : LVL_PLATFORM;
			entry.code[3:1]  = dec_chars(4'(HUND_PLATFORM), idx);
			entry.code[0]    = idx[IDX_W-1] ? CH_W : CH_E;
		end else if (faults.general_error != '0) begin
			entry.level   = LVL_GENERAL;
			entry.code[0] = faults.general_error[31:24] + CH_ZERO;
			entry.code[1] = faults.general_error[23:16] + CH_ZERO;
			entry.code[2] = faults.general_error[15:8] + CH_ZERO;
			entry.code[3] = hex_char;
		end
	end

endmodule

`default_nettype wire

// ----- design/fcd_queue.sv -----
// ----------------------------------------------------------------------------
// fcd_queue
// Two-entry queue between the classifier and the display sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_queue
	import fcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire fcd_entry_t wr_entry,
	output logic            full,
	output logic            rd_valid,
	input  wire logic       pop,
	output fcd_entry_t      rd_entry
);

	fcd_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fcd_back.sv -----
// ----------------------------------------------------------------------------
// fcd_back
// Display sequencer: hold filter on code changes, idle marquee, settings
// registers and the output register of the display channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_back
	import fcd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  q_valid,
	input  wire fcd_entry_t            q_entry,
	output logic                       pop,
	fcd_out_if.source                  display
);

	logic [HOLD_W-1:0]          hold_ticks_q;
	logic [STEP_W-1:0]          idle_step_q;
	code_t                      shown_code_q;
	logic                       showing_q;
	logic [HOLD_W-1:0]          hold_count_q;
	logic [IDLE_COUNT_BITS-1:0] idle_count_q;
	logic [1:0]                 idle_phase_q;

	logic                       out_valid_q;
	logic [LEVEL_W-1:0]         out_level_q;
	code_t                      out_code_q;
	logic                       out_write_q;

	code_t                      shown_n;
	logic                       showing_n;
	logic [HOLD_W-1:0]          hold_n;
	logic [IDLE_COUNT_BITS-1:0] idle_count_n;
	logic [1:0]                 idle_phase_n;
	code_t                      disp_n;
	logic                       write_n;

	assign pop = q_valid && (!out_valid_q || display.ready);

	assign display.valid       = out_valid_q;
	assign display.fault_level = out_level_q;
	assign display.char0       = out_code_q[0];
	assign display.char1       = out_code_q[1];
	assign display.char2       = out_code_q[2];
	assign display.char3       = out_code_q[3];
	assign display.lcd_write   = out_write_q;

	always_comb begin
		shown_n      = shown_code_q;
		showing_n    = showing_q;
		hold_n       = hold_count_q;
		idle_count_n = idle_count_q;
		idle_phase_n = idle_phase_q;
		disp_n       = '0;
		write_n      = 1'b0;

		if (q_entry.level != LVL_NONE) begin
			if (!showing_q) begin
				shown_n   = q_entry.code;
				showing_n = 1'b1;
			end
			hold_n = (shown_n != q_entry.code) ? hold_count_q + HOLD_W'(1) : '0;
			if (hold_n > hold_ticks_q) begin
				shown_n = q_entry.code;
				hold_n  = '0;
			end
		end else begin
			if (showing_q) begin
				hold_n = hold_count_q + HOLD_W'(1);
			end
			// fault gone for long enough: back to the marquee
			if (hold_n > hold_ticks_q) begin
				showing_n = 1'b0;
				hold_n    = '0;
				shown_n   = CODE_IDLE;
			end
		end

		if (showing_n) begin
			disp_n  = shown_n;
			write_n = 1'b1;
		end else begin
			if (32'(idle_count_q) >= 32'(idle_step_q)) begin
				idle_phase_n = idle_phase_q + 2'd1;
				for (int i = 0; i < 4; i++) begin
					disp_n[i] = (2'(i) == idle_phase_n) ? CH_DOLLAR : CH_EQUAL;
				end
				write_n      = 1'b1;
				idle_count_n = IDLE_COUNT_BITS'(1);
			end else begin
				idle_count_n = idle_count_q + IDLE_COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RST;
			idle_step_q  <= IDLE_STEP_RST;
			shown_code_q <= CODE_IDLE;
			showing_q    <= 1'b0;
			hold_count_q <= '0;
			idle_count_q <= '0;
			idle_phase_q <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_W-1:0];
					CFG_IDLE_STEP:  idle_step_q  <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (pop) begin
				shown_code_q <= shown_n;
				showing_q    <= showing_n;
				hold_count_q <= hold_n;
				idle_count_q <= idle_count_n;
				idle_phase_q <= idle_phase_n;
				out_valid_q  <= 1'b1;
			end else if (display.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_level_q <= q_entry.level;
			out_code_q  <= disp_n;
			out_write_q <= write_n;
		end
	end

endmodule

`default_nettype wire

// ----- design/fault_code_display_controller.sv -----
// ----------------------------------------------------------------------------
// fault_code_display_controller
// Turns one set of fault words per tick into a four-character display code.
//
// faults channel: cpu, station, platform and general error words, one item
// per tick while ready is high. display channel: fault level and four
// characters, with lcd_write high when they go to the display (else zero).
// Settings are written through cfg_we / cfg_index / cfg_data while idle:
// index 0 is the hold time in ticks, index 1 the marquee step time.
// An accepted item is written into the queue, then popped by the sequencer
// into its output register, which drives the display channel. Throughput is
// one item per cycle while the display side does not stall.
// A two-entry queue sits between the classifier and the sequencer; when the
// display side stalls the queue fills and faults.ready falls after two more
// items. Reset empties the queue, clears the output and restores the idle
// "$===" code and the default hold and step settings.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_code_display_controller
	import fcd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	fcd_in_if.sink                     faults,
	fcd_out_if.source                  display
);

	logic       push;
	logic       full;
	logic       q_valid;
	logic       pop;
	fcd_entry_t wr_entry;
	fcd_entry_t rd_entry;

	fcd_front u_front (
		.faults (faults),
		.full   (full),
		.push   (push),
		.entry  (wr_entry)
	);

	fcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.rd_valid (q_valid),
		.pop      (pop),
		.rd_entry (rd_entry)
	);

	fcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (rd_entry),
		.pop       (pop),
		.display   (display)
	);

endmodule

`default_nettype wire

// ----- design/fcd_checker.sv -----
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level checks of the fault code display controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_checker
	import fcd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [LEVEL_W-1:0] fault_level,
	input wire logic [CHAR_W-1:0]  char0,
	input wire logic [CHAR_W-1:0]  char1,
	input wire logic [CHAR_W-1:0]  char2,
	input wire logic [CHAR_W-1:0]  char3,
	input wire logic               lcd_write
);

	// characters are blank on ticks that do not write the display
	a_blank_when_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lcd_write |-> char0 == '0 && char1 == '0 && char2 == '0 &&
			char3 == '0)
		else $error("characters not zero without lcd_write");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fault_level <= LVL_GENERAL)
		else $error("fault level out of range");

	// an active fault always drives the display
	a_fault_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_level != LVL_NONE |-> lcd_write)
		else $error("active fault without display write");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fault_level) &&
			$stable(char0) && $stable(char3) && $stable(lcd_write))
		else $error("result changed while stalled");

endmodule

bind fault_code_display_controller fcd_checker u_fcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (display.valid),
	.out_ready   (display.ready),
	.fault_level (display.fault_level),
	.char0       (display.char0),
	.char1       (display.char1),
	.char2       (display.char2),
	.char3       (display.char3),
	.lcd_write   (display.lcd_write)
);

`default_nettype wire

// ----- tb/sv/fault_code_display_controller_test.sv -----
// ----------------------------------------------------------------------------
// fault_code_display_controller_test
// Drives fault word items into the display controller and checks every
// display item against an expected value from the directed table or an
// in-bench model of the priority pick, hold timer and idle marquee. A directed
// table comes first, then random fault sequences under several hold and
// marquee settings, with bursty input and a stalling display side.
// ----------------------------------------------------------------------------

module fault_code_display_controller_test;
	import fcd_pkg::*;

	typedef struct packed {
		logic [FAULT_W-1:0]   cpu;
		logic [FAULT_W-1:0]   station;
		logic [FAULT_W-1:0]   platform;
		logic [GENERAL_W-1:0] general;
	} fault_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [CHAR_W-1:0]  c0;
		logic [CHAR_W-1:0]  c1;
		logic [CHAR_W-1:0]  c2;
		logic [CHAR_W-1:0]  c3;
		logic               wr;
	} display_t;

	typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		fault_item_t           item;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  known;
		display_t              want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fcd_in_if  faults_if ();
	fcd_out_if display_if ();

	fault_code_display_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.faults    (faults_if),
		.display   (display_if)
	);

	// display model state
	logic [HOLD_W-1:0]          hold_ticks_set;
	logic [STEP_W-1:0]          step_ticks_set;
	code_t                      shown;
	logic                       fault_shown;
	logic [HOLD_W-1:0]          hold_cnt;
	logic [IDLE_COUNT_BITS-1:0] idle_cnt;
	logic [1:0]                 marquee_pos;

	display_t pending_displays [$];
	dir_row_t directed_rows [$];
	int       error_count;
	int       burst_left;
	int       sent_count;

	// display side stall pattern
	int ready_mode;
	int ready_mode_left;
	int stall_run;
	int stall_tick;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int first_set(input logic [FAULT_W-1:0] v);
		for (int i = 0; i < FAULT_W; i++) begin
			if (v[i]) begin
				return i;
			end
		end
		return FAULT_W - 1;
	endfunction

	function automatic code_t three_digit(input logic [CHAR_W-1:0] lead, input int n);
		code_t c;
		c[0] = lead;
		c[1] = CH_ZERO + CHAR_W'(n / 100);
		c[2] = CH_ZERO + CHAR_W'((n % 100) / 10);
		c[3] = CH_ZERO + CHAR_W'(n % 10);
		return c;
	endfunction

	function automatic display_t next_display(input fault_item_t it);
		logic [LEVEL_W-1:0] lvl;
		code_t              code;
		code_t              out_code;
		logic               wr;
		int                 idx;
		logic [CHAR_W-1:0]  lo;
		display_t           d;
		lvl = LVL_NONE;
		code = '0;
		out_code = '0;
		wr = 1'b0;
		if (it.cpu != '0) begin
			lvl = LVL_CPU;
			code = three_digit(CH_E, OFFSET_CPU + first_set(it.cpu));
		end else if (it.station != '0) begin
			lvl = LVL_STATION;
			code = three_digit(CH_E, OFFSET_STATION + first_set(it.station));
		end else if (it.platform != '0) begin
			idx = first_set(it.platform);
			if (idx < 32) begin
				lvl = LVL_PLATFORM;
				code = three_digit(CH_E, OFFSET_PLATFORM + idx);
			end else begin
				lvl = LVL_WARNING;
				code = three_digit(CH_W, OFFSET_PLATFORM + idx);
			end
		end else if (it.general != '0) begin
			lvl = LVL_GENERAL;
			lo = it.general[7:0];
			code[0] = it.general[31:24] + CH_ZERO;
			code[1] = it.general[23:16] + CH_ZERO;
			code[2] = it.general[15:8] + CH_ZERO;
			code[3] = (lo < 8'd10) ? lo + CH_ZERO : lo - 8'd10 + CH_A;
		end

		if (lvl != LVL_NONE) begin
			if (!fault_shown) begin
				shown = code;
				fault_shown = 1'b1;
			end
			if (shown != code) begin
				hold_cnt = hold_cnt + 1'b1;
			end else begin
				hold_cnt = '0;
			end
			if (hold_cnt > hold_ticks_set) begin
				shown = code;
				hold_cnt = '0;
			end
		end else begin
			if (fault_shown) begin
				hold_cnt = hold_cnt + 1'b1;
			end
			// a cleared code also has to outlast the hold time
			if (hold_cnt > hold_ticks_set) begin
				fault_shown = 1'b0;
				hold_cnt = '0;
				shown = CODE_IDLE;
			end
		end

		if (fault_shown) begin
			out_code = shown;
			wr = 1'b1;
		end else begin
			if (idle_cnt >= step_ticks_set) begin
				idle_cnt = '0;
				marquee_pos = marquee_pos + 1'b1;
				out_code = {4{CH_EQUAL}};
				out_code[marquee_pos] = CH_DOLLAR;
				wr = 1'b1;
			end
			idle_cnt = idle_cnt + 1'b1;
		end

		d.level = lvl;
		d.c0 = out_code[0];
		d.c1 = out_code[1];
		d.c2 = out_code[2];
		d.c3 = out_code[3];
		d.wr = wr;
		return d;
	endfunction

	function automatic display_t disp_of(input logic [LEVEL_W-1:0] level,
			input logic [CHAR_W-1:0] c0, c1, c2, c3, input logic wr);
		display_t d;
		d = '{level, c0, c1, c2, c3, wr};
		return d;
	endfunction

	function automatic dir_row_t fault_row(input logic [FAULT_W-1:0] cpu, st, pf,
			input logic [GENERAL_W-1:0] ge);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.item = '{cpu, st, pf, ge};
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic [FAULT_W-1:0] cpu, st, pf,
			input logic [GENERAL_W-1:0] ge, input display_t want);
		dir_row_t r;
		r = fault_row(cpu, st, pf, ge);
		r.known = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic dir_row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_SETTING;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// fault word whose lowest set bit is idx
	function automatic logic [FAULT_W-1:0] mask_at(input int idx);
		logic [FAULT_W-1:0] upper;
		upper = {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0) begin
			upper = '0;
		end
		return (upper << idx) | (FAULT_W'(1) << idx);
	endfunction

	function automatic fault_item_t random_fault();
		fault_item_t it;
		it.cpu = {$urandom, $urandom};
		it.station = {$urandom, $urandom};
		it.platform = {$urandom, $urandom};
		it.general = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			it.general[7:0] = 8'($urandom_range(0, 15));
		end
		// clear the higher priority words so each level gets its share
		case ($urandom_range(0, 6))
			0: it.cpu = mask_at($urandom_range(0, 63));
			1: begin
				it.cpu = '0;
				it.station = mask_at($urandom_range(0, 63));
			end
			2: begin
				it.cpu = '0;
				it.station = '0;
				it.platform = mask_at($urandom_range(0, 31));
			end
			3: begin
				it.cpu = '0;
				it.station = '0;
				it.platform = mask_at($urandom_range(32, 63));
			end
			4: begin
				it.cpu = '0;
				it.station = '0;
				it.platform = '0;
			end
			5: ;
			default: it = '0;
		endcase
		return it;
	endfunction

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(1, 40);
		return $urandom_range(0, 8);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	task automatic send_fault(input fault_item_t it, input logic known, input display_t want);
		int       gap;
		display_t predicted;
		gap = next_gap();
		@(negedge clk);
		if (gap != 0) begin
			faults_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		faults_if.valid <= 1'b1;
		faults_if.cpu_faults <= it.cpu;
		faults_if.station_faults <= it.station;
		faults_if.platform_faults <= it.platform;
		faults_if.general_error <= it.general;
		do @(posedge clk); while (!faults_if.ready);
		predicted = next_display(it);
		pending_displays.push_back(known ? want : predicted);
		sent_count++;
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		faults_if.valid <= 1'b0;
		while (pending_displays.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HOLD_TICKS) begin
			hold_ticks_set = val[HOLD_W-1:0];
		end else begin
			step_ticks_set = val[STEP_W-1:0];
		end
	endtask

	always @(negedge clk) begin
		if (ready_mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_mode_left = $urandom_range(20, 200);
		end
		ready_mode_left--;
		stall_tick++;
		case (ready_mode)
			0: display_if.ready <= 1'b1;
			1: display_if.ready <= ($urandom_range(0, 3) != 0);
			2: display_if.ready <= (stall_tick % 5 != 0);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					display_if.ready <= 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_run = $urandom_range(1, 6);
					display_if.ready <= 1'b0;
				end else begin
					display_if.ready <= 1'b1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && display_if.valid && display_if.ready) begin
			if (pending_displays.size() == 0) begin
				$error("unexpected display item: level %0h", display_if.fault_level);
				error_count++;
			end else begin
				check_field("fault_level", 8'(pending_displays[0].level),
					8'(display_if.fault_level));
				check_field("char0", pending_displays[0].c0, display_if.char0);
				check_field("char1", pending_displays[0].c1, display_if.char1);
				check_field("char2", pending_displays[0].c2, display_if.char2);
				check_field("char3", pending_displays[0].c3, display_if.char3);
				check_field("lcd_write", 8'(pending_displays[0].wr), 8'(display_if.lcd_write));
				void'(pending_displays.pop_front());
			end
		end
	end

	initial begin
		fault_item_t it;
		int          phase_end;
		int          len;
		int          kind;
		int          hold_pick;
		int          step_pick;
		fault_item_t alt;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		faults_if.valid = 1'b0;
		faults_if.cpu_faults = '0;
		faults_if.station_faults = '0;
		faults_if.platform_faults = '0;
		faults_if.general_error = '0;
		display_if.ready = 1'b0;
		error_count = 0;
		burst_left = 0;
		sent_count = 0;
		ready_mode = 0;
		ready_mode_left = 0;
		stall_run = 0;
		stall_tick = 0;

		hold_ticks_set = HOLD_TICKS_RST;
		step_ticks_set = IDLE_STEP_RST;
		shown = CODE_IDLE;
		fault_shown = 1'b0;
		hold_cnt = '0;
		idle_cnt = '0;
		marquee_pos = '0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		directed_rows = '{
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)),
			known_row(64'h1, '0, '0, '0, disp_of(LVL_CPU, CH_E, "4", "0", "0", 1'b1)),
			// differing code is held back by the default hold time
			known_row(64'h8000_0000_0000_0000, '1, '1, '1,
				disp_of(LVL_CPU, CH_E, "4", "0", "0", 1'b1)),
			setting_row(CFG_HOLD_TICKS, 20'd0),
			setting_row(CFG_IDLE_STEP, 20'd0),
			known_row(64'h8000_0000_0000_0000, '0, '0, '0,
				disp_of(LVL_CPU, CH_E, "4", "6", "3", 1'b1)),
			known_row('0, 64'h1, '1, '1, disp_of(LVL_STATION, CH_E, "3", "0", "0", 1'b1)),
			known_row('0, '1, '0, '0, disp_of(LVL_STATION, CH_E, "3", "0", "0", 1'b1)),
			known_row('0, '0, 64'h0000_0000_8000_0000, '1,
				disp_of(LVL_PLATFORM, CH_E, "2", "3", "1", 1'b1)),
			known_row('0, '0, 64'hFFFF_FFFF_0000_0000, '0,
				disp_of(LVL_WARNING, CH_W, "2", "3", "2", 1'b1)),
			known_row('0, '0, 64'h8000_0000_0000_0000, '0,
				disp_of(LVL_WARNING, CH_W, "2", "6", "3", 1'b1)),
			// byte plus '0' wraps, hex digit past 'F' wraps too
			known_row('0, '0, '0, 32'hFFFF_FFFF,
				disp_of(LVL_GENERAL, 8'h2F, 8'h2F, 8'h2F, 8'h36, 1'b1)),
			known_row('0, '0, '0, 32'h0102_0309, disp_of(LVL_GENERAL, "1", "2", "3", "9", 1'b1)),
			known_row('0, '0, '0, 32'h0000_000A, disp_of(LVL_GENERAL, "0", "0", "0", CH_A, 1'b1)),
			// cleared at once, then the marquee steps every tick
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, CH_EQUAL, CH_DOLLAR, CH_EQUAL, CH_EQUAL, 1'b1)),
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, CH_EQUAL, CH_EQUAL, CH_DOLLAR, CH_EQUAL, 1'b1)),
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, CH_EQUAL, CH_EQUAL, CH_EQUAL, CH_DOLLAR, 1'b1)),
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, CH_DOLLAR, CH_EQUAL, CH_EQUAL, CH_EQUAL, 1'b1)),
			// hold counter wraps and never passes 255
			setting_row(CFG_HOLD_TICKS, 20'd255),
			known_row(64'h20, '0, '0, '0, disp_of(LVL_CPU, CH_E, "4", "0", "5", 1'b1)),
			known_row('0, 64'h1, '0, '0, disp_of(LVL_STATION, CH_E, "4", "0", "5", 1'b1)),
			known_row('0, '0, '0, '0, disp_of(LVL_NONE, CH_E, "4", "0", "5", 1'b1)),
			fault_row('0, '0, '0, 32'h8000_0000),
			fault_row('0, '0, 64'h0000_0001_0000_0000, 32'h0000_0009),
			setting_row(CFG_IDLE_STEP, 20'hFFFFF),
			setting_row(CFG_HOLD_TICKS, 20'd1),
			fault_row('0, '0, '0, '0),
			fault_row('0, '0, '0, '0),
			fault_row('1, '1, '1, '1),
			fault_row('0, '0, '0, '0),
			fault_row('0, '0, '0, '0),
			fault_row('0, '0, '0, '0)
		};

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETTING) begin
				write_setting(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_fault(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
			end
		end

		sent_count = 0;
		while (sent_count < 1450) begin
			hold_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
			step_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20'hFFFFF) :
				$urandom_range(0, 15);
			write_setting(CFG_HOLD_TICKS, CFG_DATA_W'(hold_pick));
			write_setting(CFG_IDLE_STEP, CFG_DATA_W'(step_pick));
			phase_end = sent_count + $urandom_range(120, 240);
			if (phase_end > 1450) begin
				phase_end = 1450;
			end
			while (sent_count < phase_end) begin
				kind = $urandom_range(0, 9);
				it = random_fault();
				alt = random_fault();
				if (kind <= 4) begin
					// a fault that stays for up to four items past the hold time, 24 at most
					len = $urandom_range(1, (hold_pick + 4 > 24) ? 24 : hold_pick + 4);
				end else if (kind <= 6) begin
					it = '0;
					len = $urandom_range(1, (step_pick + 3 > 30) ? 30 : step_pick + 3);
				end else begin
					len = $urandom_range(2, 12);
				end
				if (len > phase_end - sent_count) begin
					len = phase_end - sent_count;
				end
				for (int k = 0; k < len; k++) begin
					if (kind == 7 || kind == 8) begin
						it = random_fault();
					end
					if (kind == 9) begin
						send_fault((k % 2 == 0) ? it : alt, 1'b0, '0);
					end else begin
						send_fault(it, 1'b0, '0);
					end
				end
			end
		end

		@(negedge clk);
		faults_if.valid <= 1'b0;
		while (pending_displays.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/fcd_pkg.sv
design/fcd_in_if.sv
design/fcd_out_if.sv
design/fcd_front.sv
design/fcd_queue.sv
design/fcd_back.sv
design/fault_code_display_controller.sv
design/fcd_checker.sv
tb/sv/fault_code_display_controller_test.sv
